/* hw/rtl/mpf_pkg.sv */
`timescale 1ns / 1ps
// mpf_pkg: opcodes, state encoding and fixed constants of the page framebuffer
// no dependencies

package mpf_pkg;

    typedef enum logic [1:0] {
        OP_FILL  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_BLIT  = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RDREQ,
        S_RDLAT,
        S_DONE
    } t_state;

    localparam logic [7:0] BYTE_BLACK = 8'h00;
    localparam logic [7:0] BYTE_WHITE = 8'hFF;
    localparam logic [7:0] PIX_MSB    = 8'h80;
    localparam logic [3:0] MAX_BITS   = 4'd8;
    localparam logic [3:0] ONE_BIT    = 4'd1;

    // wide enough for column + 7 plus any page times the default screen width
    localparam int CALC_W = 17;

endpackage

/* hw/rtl/mpf_in_if.sv */
`timescale 1ns / 1ps
// mpf_in_if: command channel of the page framebuffer, valid/ready with payload
// no dependencies

interface mpf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic       color;
    logic [7:0] pattern;
    logic [3:0] bit_count;

    modport source (output valid, output opcode, output x_pos, output y_pos,
                    output color, output pattern, output bit_count, input ready);
    modport sink   (input valid, input opcode, input x_pos, input y_pos,
                    input color, input pattern, input bit_count, output ready);
endinterface

/* hw/rtl/mpf_out_if.sv */
`timescale 1ns / 1ps
// mpf_out_if: result channel of the page framebuffer, valid/ready with payload
// no dependencies

interface mpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       clipped;

    modport source (output valid, output read_data, output clipped, input ready);
    modport sink   (input valid, input read_data, input clipped, output ready);
endinterface

/* hw/rtl/mpf_ram.sv */
`timescale 1ns / 1ps
// mpf_ram: generic single write port, single read port ram with registered read
// no dependencies

module mpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/mono_page_framebuffer.sv */
`timescale 1ns / 1ps
// mono_page_framebuffer: page-organized 1-bit frame store with fill, pixel, blit and read
// depends on mpf_pkg, mpf_in_if, mpf_out_if, mpf_ram
//
//   channel  dir  payload                                           beat
//   i_in     in   opcode, x_pos, y_pos, color, pattern, bit_count   i_in.valid & i_in.ready
//   o_out    out  read_data, clipped                                o_out.valid & o_out.ready
//
// one command at a time; every access goes through the frame ram, one write port and one read port
// pixel and blit scan the pattern bits, reading then writing each drawn pixel; read fetches one byte
// fill: every one of the SCREEN_WIDTH*SCREEN_HEIGHT/8 bytes is written, one byte written per cycle
// after reset the ram is swept to black, all 1024 bytes at the default size, ready low
// a finished result waits in the output register while the next command is taken

module mono_page_framebuffer #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpf_in_if.sink    i_in,
    mpf_out_if.source o_out
);

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
    localparam int PAGES = SCREEN_HEIGHT / 8;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = mpf_pkg::CALC_W;

    mpf_pkg::t_state  r_state, n_state;
    mpf_pkg::t_opcode r_op, n_op;
    logic [7:0]    r_x, n_x;
    logic [7:0]    r_y, n_y;
    logic          r_color, n_color;
    logic [7:0]    r_pattern, n_pattern;
    logic [3:0]    r_count, n_count;
    logic [3:0]    r_idx, n_idx;
    logic          r_clip, n_clip;
    logic [7:0]    r_data, n_data;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_sweep, n_sweep;
    logic [7:0]    r_fill, n_fill;
    logic          r_report, n_report;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_data, n_out_data;
    logic          r_out_clip, n_out_clip;

    logic          in_fire;
    logic          out_free;
    logic          sweep_last;
    logic          scan_end;
    logic [7:0]    shifted;
    logic          pix_req;
    logic [8:0]    col;
    logic [7:0]    page;
    logic [CW-1:0] addr_full;
    logic          row_ok;
    logic          on_screen;
    logic [7:0]    mask;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [7:0]    ram_q;

    mpf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (addr_full[AW-1:0]),
        .o_rdata (ram_q)
    );

    // address and clipping of the current pixel or read
    assign col     = 9'(r_x) + 9'(r_idx);
    assign page    = (r_op == mpf_pkg::OP_READ) ? r_y : {3'b000, r_y[7:3]};
    assign addr_full = CW'(col) + CW'(page) * CW'(SCREEN_WIDTH);
    assign row_ok  = (r_op == mpf_pkg::OP_READ) ? (CW'(r_y) < CW'(PAGES))
                                                : (CW'(r_y) < CW'(SCREEN_HEIGHT));
    assign on_screen = (CW'(col) < CW'(SCREEN_WIDTH)) && row_ok
                       && (addr_full < CW'(DEPTH));

    assign shifted  = r_pattern << r_idx[2:0];
    assign scan_end = (r_idx == r_count);
    assign pix_req  = !scan_end && shifted[7];
    assign mask     = 8'h01 << r_y[2:0];

    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign sweep_last = (r_sweep == AW'(DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpf_pkg::S_CLEAR: begin
                if (sweep_last) begin
                    n_state = r_report ? mpf_pkg::S_DONE : mpf_pkg::S_IDLE;
                end
            end
            mpf_pkg::S_IDLE: begin
                if (in_fire) begin
                    unique case (mpf_pkg::t_opcode'(i_in.opcode))
                        mpf_pkg::OP_FILL:  n_state = mpf_pkg::S_CLEAR;
                        mpf_pkg::OP_READ:  n_state = mpf_pkg::S_RDREQ;
                        mpf_pkg::OP_PIXEL,
                        mpf_pkg::OP_BLIT:  n_state = mpf_pkg::S_SCAN;
                        default:           n_state = mpf_pkg::S_IDLE;
                    endcase
                end
            end
            mpf_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = mpf_pkg::S_DONE;
                end else if (pix_req && on_screen) begin
                    n_state = mpf_pkg::S_WRITE;
                end
            end
            mpf_pkg::S_WRITE: n_state = mpf_pkg::S_SCAN;
            mpf_pkg::S_RDREQ: n_state = on_screen ? mpf_pkg::S_RDLAT : mpf_pkg::S_DONE;
            mpf_pkg::S_RDLAT: n_state = mpf_pkg::S_DONE;
            mpf_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = mpf_pkg::S_IDLE;
                end
            end
            default: n_state = mpf_pkg::S_IDLE;
        endcase
    end

    // ram and handshake outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = r_color ? (ram_q | mask) : (ram_q & ~mask);
        ram_re    = 1'b0;
        unique case (r_state)
            mpf_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = r_fill;
            end
            mpf_pkg::S_WRITE: ram_we = 1'b1;
            mpf_pkg::S_SCAN:  ram_re = pix_req && on_screen;
            mpf_pkg::S_RDREQ: ram_re = on_screen;
            default: ;
        endcase
    end

    assign i_in.ready      = (r_state == mpf_pkg::S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;
    assign o_out.clipped   = r_out_clip;

    // datapath next values
    always_comb begin
        n_op        = r_op;
        n_x         = r_x;
        n_y         = r_y;
        n_color     = r_color;
        n_pattern   = r_pattern;
        n_count     = r_count;
        n_idx       = r_idx;
        n_clip      = r_clip;
        n_data      = r_data;
        n_addr      = r_addr;
        n_sweep     = r_sweep;
        n_fill      = r_fill;
        n_report    = r_report;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_data  = r_out_data;
        n_out_clip  = r_out_clip;
        unique case (r_state)
            mpf_pkg::S_CLEAR: n_sweep = r_sweep + AW'(1);
            mpf_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_op     = mpf_pkg::t_opcode'(i_in.opcode);
                    n_x      = i_in.x_pos;
                    n_y      = i_in.y_pos;
                    n_color  = i_in.color;
                    n_idx    = '0;
                    n_clip   = 1'b0;
                    n_data   = mpf_pkg::BYTE_BLACK;
                    n_sweep  = '0;
                    n_fill   = i_in.color ? mpf_pkg::BYTE_WHITE : mpf_pkg::BYTE_BLACK;
                    n_report = 1'b1;
                    if (mpf_pkg::t_opcode'(i_in.opcode) == mpf_pkg::OP_PIXEL) begin
                        n_pattern = mpf_pkg::PIX_MSB;
                        n_count   = mpf_pkg::ONE_BIT;
                    end else begin
                        n_pattern = i_in.pattern;
                        n_count   = (i_in.bit_count > mpf_pkg::MAX_BITS)
                                    ? mpf_pkg::MAX_BITS : i_in.bit_count;
                    end
                end
            end
            mpf_pkg::S_SCAN: begin
                if (!scan_end) begin
                    if (pix_req && on_screen) begin
                        n_addr = addr_full[AW-1:0];
                    end else begin
                        n_clip = r_clip || pix_req;
                        n_idx  = r_idx + 4'd1;
                    end
                end
            end
            mpf_pkg::S_WRITE: n_idx = r_idx + 4'd1;
            mpf_pkg::S_RDREQ: n_clip = !on_screen;
            mpf_pkg::S_RDLAT: n_data = ram_q;
            mpf_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data;
                    n_out_clip  = r_clip;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mpf_pkg::S_CLEAR;
            r_sweep     <= '0;
            r_fill      <= mpf_pkg::BYTE_BLACK;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_fill      <= n_fill;
            r_report    <= n_report;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_x        <= n_x;
        r_y        <= n_y;
        r_color    <= n_color;
        r_pattern  <= n_pattern;
        r_count    <= n_count;
        r_idx      <= n_idx;
        r_clip     <= n_clip;
        r_data     <= n_data;
        r_addr     <= n_addr;
        r_out_data <= n_out_data;
        r_out_clip <= n_out_clip;
    end

endmodule

/* hw/rtl/mpf_checker.sv */
`timescale 1ns / 1ps
// mpf_checker: port-level checks on the page framebuffer channels
// bound to mono_page_framebuffer; no other dependencies

module mpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_read_data,
    input logic       i_clipped
);

    logic       in_fire;
    logic       out_fire;
    logic [1:0] r_open;

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;

    // commands taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 2'd0;
        end else begin
            r_open <= r_open + 2'(in_fire) - 2'(out_fire);
        end
    end

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |-> (r_open != 2'd0))
        else $error("result beat with no open command");

    a_one_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (r_open != 2'd2) || out_fire)
        else $error("command beat taken with two results open");

    a_clip_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_clipped) |-> (i_read_data == 8'h00))
        else $error("clipped result carries data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_read_data) && $stable(i_clipped)))
        else $error("stalled result beat changed");

endmodule

bind mono_page_framebuffer mpf_checker u_mpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_read_data (o_out.read_data),
    .i_clipped   (o_out.clipped)
);
